/* hw/rtl/ctn_pkg.sv */
// Shared types, constants and codes for the CAN torque node frame handler.
// No dependencies; every other file of the block imports this package.
package ctn_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_FRAME    = 2'd0;
    localparam logic [1:0] REQ_TICK     = 2'd1;
    localparam logic [1:0] REQ_FEEDBACK = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_ID    = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_MS = 8'd1;

    localparam logic [25:0] NODE_ID_RESET    = 26'd1;
    localparam logic [15:0] TIMEOUT_MS_RESET = 16'd100;

    // Identifiers.
    localparam logic [10:0] DISCOVER_STD_ID = 11'h700;
    localparam logic [28:0] FB_FRAME_ID     = 29'h0400_0000;
    localparam logic [28:0] REPLY_FRAME_ID  = 29'h0800_0000;

    localparam logic [3:0]  CMD_DLC      = 4'd4;
    localparam logic [3:0]  FEEDBACK_DLC = 4'd8;
    localparam logic [16:0] AGE_MAX      = 17'h1_FFFF;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               rx_extended;
        logic               rx_remote;
        logic [28:0]        rx_id;
        logic [3:0]         rx_dlc;
        logic [63:0]        rx_data;
        logic [15:0]        fb_timestamp;
        logic signed [31:0] fb_count;
    } t_item;

    typedef struct packed {
        logic signed [31:0] target_mnm;
        logic               tx_valid;
        logic               tx_extended;
        logic [28:0]        tx_id;
        logic [3:0]         tx_dlc;
        logic [63:0]        tx_data;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           data;
    } t_cfg_wr;

endpackage

/* hw/rtl/ctn_ifs.sv */
// Handshake interfaces of the CAN torque node frame handler: request,
// result and configuration write channels. Depends on ctn_pkg.
interface ctn_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic               rx_extended;
    logic               rx_remote;
    logic [28:0]        rx_id;
    logic [3:0]         rx_dlc;
    logic [63:0]        rx_data;
    logic [15:0]        fb_timestamp;
    logic signed [31:0] fb_count;

    modport source (
        output valid, req_type, rx_extended, rx_remote, rx_id, rx_dlc, rx_data,
               fb_timestamp, fb_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, rx_extended, rx_remote, rx_id, rx_dlc, rx_data,
               fb_timestamp, fb_count,
        output ready
    );
endinterface

interface ctn_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_mnm;
    logic               tx_valid;
    logic               tx_extended;
    logic [28:0]        tx_id;
    logic [3:0]         tx_dlc;
    logic [63:0]        tx_data;

    modport source (
        output valid, target_mnm, tx_valid, tx_extended, tx_id, tx_dlc, tx_data,
        input  ready
    );
    modport sink (
        input  valid, target_mnm, tx_valid, tx_extended, tx_id, tx_dlc, tx_data,
        output ready
    );
endinterface

interface ctn_cfg_if import ctn_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

/* hw/rtl/ctn_f2i.sv */
// Converts a binary32 torque in newton metres to saturated int32 milli newton
// metres (product rounded to nearest even, then truncated). Uses ctn_pkg.
module ctn_f2i
    import ctn_pkg::*;
(
    input  logic [31:0]        i_bits,
    output logic signed [31:0] o_mnm
);

    always_comb begin
        logic               neg;
        logic [7:0]         ef;
        logic [23:0]        mant;
        logic [33:0]        p;
        logic [23:0]        q0;
        logic               guard;
        logic               sticky;
        logic [24:0]        qr;
        logic [23:0]        q;
        logic [4:0]         sh;
        logic signed [10:0] e;
        logic [10:0]        ne;
        logic [30:0]        mag;
        logic               sat;

        neg  = i_bits[31];
        ef   = i_bits[30:23];
        mant = {1'b1, i_bits[22:0]};
        p    = {10'b0, mant} * 34'd1000;

        // A normal mantissa times 1000 is 33 or 34 bits long, so rounding
        // to 24 bits drops either 9 or 10 bits.
        if (p[33]) begin
            q0     = p[33:10];
            guard  = p[9];
            sticky = |p[8:0];
            sh     = 5'd10;
        end else begin
            q0     = p[32:9];
            guard  = p[8];
            sticky = |p[7:0];
            sh     = 5'd9;
        end
        qr = {1'b0, q0} + {24'b0, guard & (sticky | q0[0])};
        if (qr[24]) begin
            q  = qr[24:1];
            sh = sh + 5'd1;
        end else begin
            q = qr[23:0];
        end

        e   = $signed({3'b0, ef}) + $signed({6'b0, sh}) - 11'sd150;
        ne  = 11'(-e);
        sat = 1'b0;
        mag = '0;
        if (e >= 11'sd8) begin
            // Any magnitude of 2^31 or more saturates.
            sat = 1'b1;
        end else if (e >= 11'sd0) begin
            mag = 31'(q) << e[2:0];
        end else if (e > -11'sd24) begin
            mag = 31'(q >> ne[4:0]);
        end

        if (ef == 8'hFF) begin
            if (i_bits[22:0] != 23'd0) begin
                o_mnm = '0;
            end else begin
                o_mnm = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end else if (ef == 8'h00) begin
            // Zero and subnormals scale to well below one milli newton metre.
            o_mnm = '0;
        end else if (sat) begin
            o_mnm = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (neg) begin
            o_mnm = $signed(32'd0 - {1'b0, mag});
        end else begin
            o_mnm = $signed({1'b0, mag});
        end
    end

endmodule

/* hw/rtl/ctn_core.sv */
// Configuration registers, node state and the per-request step logic of the
// CAN torque node frame handler. Uses ctn_pkg and ctn_f2i.
module ctn_core
    import ctn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg_wr,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [25:0]        r_node_id;
    logic [15:0]        r_timeout_ms;
    logic signed [31:0] r_held_target, n_held_target;
    logic [16:0]        r_target_age, n_target_age;
    logic [15:0]        r_fb_seq, n_fb_seq;
    logic signed [31:0] cmd_mnm;

    ctn_f2i u_f2i (
        .i_bits (i_item.rx_data[31:0]),
        .o_mnm  (cmd_mnm)
    );

    always_comb begin
        logic is_discover;
        logic is_command;

        n_held_target = r_held_target;
        n_target_age  = r_target_age;
        n_fb_seq      = r_fb_seq;
        o_result      = '0;

        is_discover = !i_item.rx_extended && !i_item.rx_remote &&
                      (i_item.rx_id[10:0] == DISCOVER_STD_ID) && (i_item.rx_dlc == 4'd0);
        is_command  = i_item.rx_extended && !i_item.rx_remote &&
                      (i_item.rx_id == {3'b0, r_node_id}) && (i_item.rx_dlc == CMD_DLC);

        case (i_item.req_type)
            REQ_FRAME: begin
                if (is_discover) begin
                    o_result.tx_valid    = 1'b1;
                    o_result.tx_extended = 1'b1;
                    o_result.tx_id       = REPLY_FRAME_ID | {3'b0, r_node_id};
                end else if (is_command) begin
                    n_held_target = cmd_mnm;
                    n_target_age  = '0;
                end
            end
            REQ_TICK: begin
                if (r_target_age != AGE_MAX) begin
                    n_target_age = r_target_age + 17'd1;
                end
            end
            REQ_FEEDBACK: begin
                n_fb_seq             = r_fb_seq + 16'd1;
                o_result.tx_valid    = 1'b1;
                o_result.tx_extended = 1'b1;
                o_result.tx_id       = FB_FRAME_ID | {3'b0, r_node_id};
                o_result.tx_dlc      = FEEDBACK_DLC;
                o_result.tx_data     = {i_item.fb_count, i_item.fb_timestamp, n_fb_seq};
            end
            default: begin
            end
        endcase

        // A target older than the timeout reads as zero.
        o_result.target_mnm = (n_target_age > {1'b0, r_timeout_ms}) ? 32'sd0 : n_held_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= NODE_ID_RESET;
            r_timeout_ms  <= TIMEOUT_MS_RESET;
            r_held_target <= '0;
            r_target_age  <= '0;
            r_fb_seq      <= '0;
        end else begin
            if (i_cfg_wr.we) begin
                case (i_cfg_wr.addr)
                    CFG_NODE_ID:    r_node_id    <= i_cfg_wr.data[25:0];
                    CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_wr.data[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_held_target <= n_held_target;
                r_target_age  <= n_target_age;
                r_fb_seq      <= n_fb_seq;
            end
        end
    end

endmodule

/* hw/rtl/can_torque_node_frame_handler.sv */
// Top level of the CAN torque node frame handler: request register, step
// logic and result register. Uses ctn_pkg, ctn_ifs and ctn_core.
//
//   Channel  Direction  Moves per request
//   i_req    in         one received frame, tick or feedback request
//   o_rsp    out        one result: torque target and optional transmit frame
//   i_cfg    in         one register write (node identity, timeout)
//
// A request accepted into the request register is stepped once the result
// register is free or being emptied, and the step loads the result register,
// from which its result is taken. A new request can be accepted every cycle
// while o_rsp does not stall; the single pass through the step logic and the
// float conversion between the two registers sets that rate.
// Reset is synchronous and active low; it restores the node identity to 1,
// timeout_ms to 100 and clears the target, its age and the feedback sequence.
// When o_rsp stalls, the result register holds and the request register still
// takes one more request; i_req.ready drops only when both are full.
// Configuration writes are always taken and are meant for idle periods.
module can_torque_node_frame_handler
    import ctn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctn_req_if.sink    i_req,
    ctn_rsp_if.source  o_rsp,
    ctn_cfg_if.sink    i_cfg
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    t_cfg_wr cfg_wr;
    logic    out_load;
    logic    in_take;

    // The step fires when a request waits and the result register is free
    // or being emptied in this cycle.
    assign out_load = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_take  = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_valid || out_load;
    assign i_cfg.ready = 1'b1;

    assign cfg_wr.we   = i_cfg.valid;
    assign cfg_wr.addr = i_cfg.addr;
    assign cfg_wr.data = i_cfg.data;

    ctn_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_fire   (out_load),
        .i_item   (r_in),
        .o_result (step_result)
    );

    // Request register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    // Request payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type     <= i_req.req_type;
            r_in.rx_extended  <= i_req.rx_extended;
            r_in.rx_remote    <= i_req.rx_remote;
            r_in.rx_id        <= i_req.rx_id;
            r_in.rx_dlc       <= i_req.rx_dlc;
            r_in.rx_data      <= i_req.rx_data;
            r_in.fb_timestamp <= i_req.fb_timestamp;
            r_in.fb_count     <= i_req.fb_count;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= step_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.target_mnm  = r_out.target_mnm;
    assign o_rsp.tx_valid    = r_out.tx_valid;
    assign o_rsp.tx_extended = r_out.tx_extended;
    assign o_rsp.tx_id       = r_out.tx_id;
    assign o_rsp.tx_dlc      = r_out.tx_dlc;
    assign o_rsp.tx_data     = r_out.tx_data;

endmodule
